// ----- hdl/gradient_ramp_sampler_unit_defines.svh -----
// assertion macros shared by the gradient ramp sampler rtl
// needs a clock named clk and an active high reset named rst in the using scope
`ifndef GRADIENT_RAMP_SAMPLER_UNIT_DEFINES_SVH
`define GRADIENT_RAMP_SAMPLER_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define GRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define GRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/grs_pkg.sv -----
// types and constants for the gradient ramp sampler
// no dependencies
package grs_pkg;

  localparam int CH_W           = 8;
  localparam int LANES          = 4;
  localparam int PROD_W         = 2 * CH_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = CH_W / BITS_PER_STAGE;

  // input item codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // register map, selected by paddr[2]
  localparam logic        REG_STOP_COUNT  = 1'b0;
  localparam logic [31:0] STOP_COUNT_MASK = 32'h0000_000F;

  // one stop as held in the stop memory
  typedef struct packed {
    logic [CH_W-1:0]         ratio;
    logic [LANES*CH_W-1:0]   color;
  } stop_entry_t;

  // one color channel on its way through the divider
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [CH_W-1:0]   q;
    logic [CH_W-1:0]   den;
    logic              neg;
    logic [CH_W-1:0]   c0;
  } lane_t;

  typedef struct packed {
    logic                  valid;
    lane_t [LANES-1:0]     lane;
  } div_stage_t;

endpackage

// ----- hdl/gradient_ramp_sampler_unit.sv -----
// gradient ramp sampler: stop table, stop search, per-channel lerp via pipelined divider
// a sample result passes the search, memory read, product and divider stages, then the output register
// throughput: one transaction per cycle; one enable stalls every stage while out is held
// reset: clears stage valid bits and sets stop_count to 1; stop table is not reset
// depends on grs_pkg and gradient_ramp_sampler_unit_defines.svh
`include "gradient_ramp_sampler_unit_defines.svh"

module gradient_ramp_sampler_unit
  import grs_pkg::*;
#(
  parameter int MAX_STOPS = 15
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [3:0]  stop_index,
  input  logic [7:0]  stop_ratio,
  input  logic [7:0]  stop_red,
  input  logic [7:0]  stop_green,
  input  logic [7:0]  stop_blue,
  input  logic [7:0]  stop_alpha,
  input  logic [7:0]  sample_ratio,
  // result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);

  localparam int          IDX_W   = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam logic [3:0]  MAX_CNT = 4'(MAX_STOPS);

  // configuration register
  logic [3:0] stop_count;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == REG_STOP_COUNT) ? {28'b0, stop_count} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= 4'd1;
    end else if (cfg_write && (paddr[2] == REG_STOP_COUNT)) begin
      stop_count <= 4'(pwdata & STOP_COUNT_MASK);
    end
  end

  // effective count: zero reads as one, large values clamp to the table size
  logic [3:0] n_eff;
  always_comb begin
    n_eff = stop_count;
    if (stop_count == 4'd0) begin
      n_eff = 4'd1;
    end else if (stop_count > MAX_CNT) begin
      n_eff = MAX_CNT;
    end
  end

  // global pipeline enable
  logic en;
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  logic in_fire;
  logic load_wr;
  assign in_fire = in_valid & in_ready;
  assign load_wr = in_fire && (mode == MODE_LOAD) && (stop_index < MAX_CNT);

  // stop ratios in flops for the parallel search, full stops in a two-read memory
  logic [CH_W-1:0] ratio_reg [MAX_STOPS];
  stop_entry_t     stop_mem  [MAX_STOPS];

  logic [IDX_W-1:0] lo_idx;
  logic [IDX_W-1:0] hi_idx;
  logic             s1_copy;

  stop_entry_t      s2_lo;
  stop_entry_t      s2_hi;

  always_ff @(posedge clk) begin
    if (load_wr) begin
      ratio_reg[stop_index[IDX_W-1:0]] <= stop_ratio;
      stop_mem[stop_index[IDX_W-1:0]]  <= '{ratio: stop_ratio,
                                            color: {stop_alpha, stop_blue,
                                                    stop_green, stop_red}};
    end
    if (en) begin
      s2_lo <= stop_mem[lo_idx];
      s2_hi <= stop_mem[hi_idx];
    end
  end

  // stage 1: captured sample ratio
  logic            s1_valid;
  logic [CH_W-1:0] s1_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_fire && (mode == MODE_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ratio <= sample_ratio;
    end
  end

  // stage 1 search: first stop past the head whose ratio reaches the sample
  logic             found;
  logic [IDX_W-1:0] fidx;

  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = MAX_STOPS - 1; i >= 1; i--) begin
      if ((4'(i) < n_eff) && (ratio_reg[i] >= s1_ratio)) begin
        found = 1'b1;
        fidx  = IDX_W'(i);
      end
    end
    if (s1_ratio < ratio_reg[0]) begin
      lo_idx  = '0;
      hi_idx  = '0;
      s1_copy = 1'b1;
    end else if (found) begin
      lo_idx  = fidx - IDX_W'(1);
      hi_idx  = fidx;
      s1_copy = 1'b0;
    end else begin
      lo_idx  = IDX_W'(n_eff - 4'd1);
      hi_idx  = IDX_W'(n_eff - 4'd1);
      s1_copy = 1'b1;
    end
  end

  // stage 2: stop pair read back from memory
  logic            s2_valid;
  logic [CH_W-1:0] s2_ratio;
  logic            s2_copy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ratio <= s1_ratio;
      s2_copy  <= s1_copy;
    end
  end

  // stage 2 math: span, offset and per-channel |c1-c0|*t
  logic [CH_W:0]   den_wide;
  logic [CH_W-1:0] t_off;
  logic            copy2;
  div_stage_t      div_in;

  always_comb begin
    logic [CH_W:0]   diff;
    logic [CH_W-1:0] mag;
    logic [CH_W-1:0] c0;
    logic [CH_W-1:0] c1;
    den_wide     = {1'b0, s2_hi.ratio} - {1'b0, s2_lo.ratio};
    t_off        = s2_ratio - s2_lo.ratio;
    copy2        = s2_copy | den_wide[CH_W] | (den_wide == '0);
    div_in.valid = s2_valid;
    for (int k = 0; k < LANES; k++) begin
      c0   = s2_lo.color[k*CH_W +: CH_W];
      c1   = s2_hi.color[k*CH_W +: CH_W];
      diff = {1'b0, c1} - {1'b0, c0};
      mag  = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
      div_in.lane[k].c0  = c0;
      div_in.lane[k].neg = diff[CH_W];
      div_in.lane[k].q   = '0;
      if (copy2) begin
        div_in.lane[k].rem = '0;
        div_in.lane[k].den = CH_W'(1);
      end else begin
        div_in.lane[k].rem = PROD_W'(mag) * PROD_W'(t_off);
        div_in.lane[k].den = den_wide[CH_W-1:0];
      end
    end
  end

  // restoring divider step: two quotient bits per stage, msb first
  function automatic lane_t div_step(lane_t l, int unsigned k);
    lane_t           r;
    logic [PROD_W-1:0] dsh;
    int unsigned     j;
    r = l;
    for (int unsigned b = 0; b < BITS_PER_STAGE; b++) begin
      j   = CH_W - 1 - k * BITS_PER_STAGE - b;
      dsh = PROD_W'(r.den) << j;
      if (r.rem >= dsh) begin
        r.rem  = r.rem - dsh;
        r.q[j] = 1'b1;
      end
    end
    return r;
  endfunction

  // stage 3 holds products, stages 4 to 7 run the divider
  div_stage_t pipe [DIV_STAGES + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
        pipe[s].valid <= 1'b0;
      end
    end else if (en) begin
      pipe[0].valid <= div_in.valid;
      for (int s = 0; s < DIV_STAGES; s++) begin
        pipe[s+1].valid <= pipe[s].valid;
      end
    end
    if (en) begin
      pipe[0].lane <= div_in.lane;
      for (int s = 0; s < DIV_STAGES; s++) begin
        for (int k = 0; k < LANES; k++) begin
          pipe[s+1].lane[k] <= div_step(pipe[s].lane[k], s);
        end
      end
    end
  end

  // final: floor of the signed quotient, ceiling of the magnitude when negative
  logic [CH_W-1:0] res [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (pipe[DIV_STAGES].lane[k].neg) begin
        res[k] = pipe[DIV_STAGES].lane[k].c0 - pipe[DIV_STAGES].lane[k].q
                 - CH_W'(pipe[DIV_STAGES].lane[k].rem != '0);
      end else begin
        res[k] = pipe[DIV_STAGES].lane[k].c0 + pipe[DIV_STAGES].lane[k].q;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pipe[DIV_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_red   <= res[0];
      out_green <= res[1];
      out_blue  <= res[2];
      out_alpha <= res[3];
    end
  end

  // checks on the search, the divider and the stop table
  `GRS_ASSERT_NOW(a_pair_order, s1_valid,
    (lo_idx <= hi_idx) && (int'(hi_idx) < MAX_STOPS), "stop pair index out of order")

  `GRS_ASSERT_NEXT(a_load_head, in_fire && (mode == MODE_LOAD) && (stop_index == 4'd0),
    ratio_reg[0] == $past(stop_ratio), "head stop ratio not written")

  for (genvar g = 0; g < LANES; g++) begin : g_chk
    `GRS_ASSERT_NOW(a_den_nonzero, pipe[0].valid,
      pipe[0].lane[g].den != '0, "divider span is zero")
    `GRS_ASSERT_NOW(a_rem_bound, pipe[DIV_STAGES].valid,
      pipe[DIV_STAGES].lane[g].rem < PROD_W'(pipe[DIV_STAGES].lane[g].den),
      "divider remainder not below span")
  end

endmodule

// ----- tb/sv/gradient_ramp_sampler_unit_tb.sv -----
// self-checking testbench for the gradient ramp sampler: stop loads, ramp samples, apb setup
// depends on grs_pkg and the gradient_ramp_sampler_unit rtl
`timescale 1ns / 100ps

module gradient_ramp_sampler_unit_tb
  import grs_pkg::*;
();

  localparam int STOP_SLOTS     = 15;
  localparam int RESULT_LATENCY = 7;
  localparam int DRAIN_CYCLES   = RESULT_LATENCY + 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 200;
  localparam int REPORT_LIMIT   = 40;

  // apb byte addresses
  localparam logic [2:0] ADDR_STOP_COUNT = {REG_STOP_COUNT, 2'b00};
  localparam logic [2:0] ADDR_SPARE      = 3'b100;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic       mode;
    logic [3:0] slot;
    logic [7:0] ratio;
    rgba_t      color;
    logic [7:0] position;
  } ramp_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [3:0]  stop_index;
  logic [7:0]  stop_ratio;
  logic [7:0]  stop_red;
  logic [7:0]  stop_green;
  logic [7:0]  stop_blue;
  logic [7:0]  stop_alpha;
  logic [7:0]  sample_ratio;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;

  bit hold_request = 1'b0;

  gradient_ramp_sampler_unit #(.MAX_STOPS(STOP_SLOTS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .stop_index(stop_index), .stop_ratio(stop_ratio),
    .stop_red(stop_red), .stop_green(stop_green),
    .stop_blue(stop_blue), .stop_alpha(stop_alpha),
    .sample_ratio(sample_ratio),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_alpha(out_alpha)
  );

  // stop table mirror, ramp color prediction and result comparison
  class ramp_scoreboard;
    logic [7:0] stop_pos [STOP_SLOTS];
    rgba_t      stop_rgba [STOP_SLOTS];
    logic [3:0] stops_used;
    rgba_t      pending_colors [$];
    int         errors;
    string      lane_names [4];

    function new();
      stops_used = 4'd1;
      errors     = 0;
      lane_names = '{"alpha", "blue", "green", "red"};
      for (int i = 0; i < STOP_SLOTS; i++) begin
        stop_pos[i]  = '0;
        stop_rgba[i] = '0;
      end
    endfunction

    // floor-rounded lerp of one channel, flat when the span is empty or negative
    function logic [7:0] blend_channel(logic [7:0] c0, logic [7:0] c1, int t, int den);
      int diff;
      int num;
      int q;
      if (den <= 0) return c0;
      diff = int'(c1) - int'(c0);
      num  = diff * t;
      q    = (num >= 0) ? num / den : -((-num + den - 1) / den);
      return 8'(int'(c0) + q);
    endfunction

    function rgba_t predict_color(logic [7:0] pos);
      int    n;
      int    t;
      int    den;
      rgba_t lo;
      rgba_t hi;
      rgba_t res;
      n = (stops_used == 4'd0) ? 1 : int'(stops_used);
      if (n > STOP_SLOTS) n = STOP_SLOTS;
      if (pos < stop_pos[0]) return stop_rgba[0];
      for (int i = 1; i < n; i++) begin
        if (stop_pos[i] >= pos) begin
          lo  = stop_rgba[i-1];
          hi  = stop_rgba[i];
          t   = int'(pos) - int'(stop_pos[i-1]);
          den = int'(stop_pos[i]) - int'(stop_pos[i-1]);
          res.red   = blend_channel(lo.red, hi.red, t, den);
          res.green = blend_channel(lo.green, hi.green, t, den);
          res.blue  = blend_channel(lo.blue, hi.blue, t, den);
          res.alpha = blend_channel(lo.alpha, hi.alpha, t, den);
          return res;
        end
      end
      return stop_rgba[n-1];
    endfunction

    function void apply_register_write(logic [2:0] addr, logic [31:0] data);
      if (addr[2] == REG_STOP_COUNT) stops_used = 4'(data & STOP_COUNT_MASK);
    endfunction

    // accepted input transaction: update the table or queue a color
    function void take_transaction(ramp_item_t it);
      if (it.mode == MODE_LOAD) begin
        if (it.slot < STOP_SLOTS) begin
          stop_pos[it.slot]  = it.ratio;
          stop_rgba[it.slot] = it.color;
        end
      end else begin
        pending_colors.push_back(predict_color(it.position));
      end
    endfunction

    // accepted result transaction against the oldest queued color
    function void compare_color(rgba_t got);
      rgba_t want;
      if (pending_colors.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected color, expected none, actual %h", $time, got);
        return;
      end
      want = pending_colors.pop_front();
      for (int c = 0; c < 4; c++) begin
        if (got[8*c +: 8] !== want[8*c +: 8]) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                     lane_names[c], want[8*c +: 8], got[8*c +: 8]);
        end
      end
    endfunction
  endclass

  ramp_scoreboard ramp_sb;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transaction builders
  function automatic rgba_t random_color();
    logic [31:0] v;
    v = $urandom;
    for (int c = 0; c < 4; c++)
      case ($urandom_range(0, 9))
        0: v[8*c +: 8] = 8'h00;
        1: v[8*c +: 8] = 8'hFF;
        default: ;
      endcase
    return v;
  endfunction

  function automatic ramp_item_t load_item(logic [3:0] slot, logic [7:0] ratio, rgba_t color);
    ramp_item_t it;
    it.mode     = MODE_LOAD;
    it.slot     = slot;
    it.ratio    = ratio;
    it.color    = color;
    it.position = 8'($urandom);
    return it;
  endfunction

  function automatic ramp_item_t sample_item(logic [7:0] pos);
    ramp_item_t it;
    it.mode     = MODE_SAMPLE;
    it.slot     = 4'($urandom);
    it.ratio    = 8'($urandom);
    it.color    = $urandom;
    it.position = pos;
    return it;
  endfunction

  // mostly samples, some aimed at stop boundaries; loads may hit the unused slot
  function automatic ramp_item_t random_item(bit only_samples);
    int k;
    if (only_samples || $urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, STOP_SLOTS - 1);
        return sample_item(8'(int'(ramp_sb.stop_pos[k]) + $urandom_range(0, 2) - 1));
      end
      return sample_item(8'($urandom_range(0, 255)));
    end
    return load_item(4'($urandom_range(0, 15)), 8'($urandom), random_color());
  endfunction

  // input side driver
  task automatic send_transaction(input ramp_item_t it);
    @(negedge clk);
    in_valid     <= 1'b1;
    mode         <= it.mode;
    stop_index   <= it.slot;
    stop_ratio   <= it.ratio;
    stop_red     <= it.color.red;
    stop_green   <= it.color.green;
    stop_blue    <= it.color.blue;
    stop_alpha   <= it.color.alpha;
    sample_ratio <= it.position;
    do @(posedge clk); while (!in_ready);
  endtask

  // idle input with junk payload
  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid     <= 1'b0;
      mode         <= 1'($urandom);
      stop_index   <= 4'($urandom);
      stop_ratio   <= 8'($urandom);
      stop_red     <= 8'($urandom);
      stop_green   <= 8'($urandom);
      stop_blue    <= 8'($urandom);
      stop_alpha   <= 8'($urandom);
      sample_ratio <= 8'($urandom);
    end
  endtask

  // stop sending and let queued colors and trailing loads drain
  task automatic wait_results_drained();
    idle_input(1);
    while (ramp_sb.pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ramp_sb.apply_register_write(addr, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // monitor accepted transactions on both channels
  always @(posedge clk) begin
    ramp_item_t seen;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen = {mode, stop_index, stop_ratio, stop_red, stop_green, stop_blue,
                stop_alpha, sample_ratio};
        ramp_sb.take_transaction(seen);
      end
      if (out_valid && out_ready)
        ramp_sb.compare_color({out_red, out_green, out_blue, out_alpha});
    end
  end

  // result side stall pattern, with a long hold-off on request
  initial begin
    int seg_left;
    int seg_style;
    out_ready = 1'b0;
    seg_left  = 0;
    seg_style = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_style = $urandom_range(0, 3);
          seg_left  = $urandom_range(1, 64);
        end
        seg_left--;
        case (seg_style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= !out_ready;
        endcase
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int         phase;
    int         sent_in_phase;
    int         burst_left;
    int         pos;
    logic [3:0] stops_cfg;

    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    mode         = MODE_LOAD;
    stop_index   = '0;
    stop_ratio   = '0;
    stop_red     = '0;
    stop_green   = '0;
    stop_blue    = '0;
    stop_alpha   = '0;
    sample_ratio = '0;
    burst_left   = 0;
    ramp_sb      = new();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: fill every slot with ascending stops, alternating extreme red and green
    for (int i = 0; i < STOP_SLOTS; i++)
      send_transaction(load_item(4'(i), 8'(10 + 17 * i),
                                 {(i % 2 == 1) ? 8'hFF : 8'h00, (i % 2 == 1) ? 8'h00 : 8'hFF,
                                  8'(i * 37), 8'(255 - i * 19)}));
    // slot past the table end, must be dropped
    send_transaction(load_item(4'd15, 8'h00, 32'hAA55_AA55));
    // single stop after reset: flat ramp
    send_transaction(sample_item(8'd0));
    send_transaction(sample_item(8'd255));
    wait_results_drained();
    write_register(ADDR_STOP_COUNT, 32'd15);
    // below first stop, on a stop, between stops, past last stop
    send_transaction(sample_item(8'd0));
    send_transaction(sample_item(8'd10));
    send_transaction(sample_item(8'd20));
    send_transaction(sample_item(8'd27));
    send_transaction(sample_item(8'd255));
    // first two stops at the same ratio
    send_transaction(load_item(4'd1, 8'd10, 32'h1234_5678));
    send_transaction(sample_item(8'd10));
    send_transaction(sample_item(8'd11));
    // stop out of order
    send_transaction(load_item(4'd2, 8'd3, 32'hFF00_80C0));
    send_transaction(sample_item(8'd12));
    wait_results_drained();
    // unmapped register, count stays at 15
    write_register(ADDR_SPARE, 32'd3);
    send_transaction(sample_item(8'd200));
    wait_results_drained();
    // zero stop count acts as one stop
    write_register(ADDR_STOP_COUNT, 32'd0);
    send_transaction(sample_item(8'd100));

    // random phases, each with its own stop count
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: stops_cfg = 4'd15;
        1: stops_cfg = 4'd0;
        2: stops_cfg = 4'd1;
        3: stops_cfg = 4'd2;
        PHASES - 1: stops_cfg = 4'd15;
        default: stops_cfg = 4'($urandom_range(0, 15));
      endcase
      wait_results_drained();
      write_register(ADDR_STOP_COUNT, ($urandom & ~STOP_COUNT_MASK) | 32'(stops_cfg));
      if ($urandom_range(0, 2) == 0) write_register(ADDR_SPARE, $urandom);
      sent_in_phase = 0;

      // ascending reload of the whole table so samples hit real spans
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        pos = $urandom_range(0, 30);
        for (int i = 0; i < STOP_SLOTS; i++) begin
          send_transaction(load_item(4'(i), 8'(pos), random_color()));
          pos = pos + $urandom_range(0, 20);
          if (pos > 255) pos = 255;
        end
        sent_in_phase += STOP_SLOTS;
      end

      // back-to-back samples against a held-off result side
      if (phase == 0) begin
        hold_request = 1'b1;
        for (int k = 0; k < 80; k++) send_transaction(random_item(1'b1));
        sent_in_phase += 80;
      end

      while (sent_in_phase < PHASE_ITEMS) begin
        if (phase == 4 && sent_in_phase == PHASE_ITEMS / 2) wait_results_drained();
        if (burst_left == 0) begin
          idle_input($urandom_range(1, 12));
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 24);
        end
        burst_left--;
        send_transaction(random_item(1'b0));
        sent_in_phase++;
      end
    end

    wait_results_drained();
    if (ramp_sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
